/* rtl/ffa_pkg.sv */
// Shared types, codes and defaults for the first-fit block allocator.
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int FFA_TOTAL_UNITS = 512;
  localparam int FFA_TABLE_SLOTS = 32;

  localparam int OWNER_W  = 8;
  localparam int REQ_W    = 10;
  localparam int OFFSET_W = 9;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREED     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_UP_RD,
    S_UP_WR,
    S_SPLIT_WR,
    S_TAKE_WR,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_DN_RD,
    S_DN_WR,
    S_PREV_RD,
    S_PREV_CHK,
    S_PMERGE_WR,
    S_REL_WR,
    S_DONE
  } state_t;

  // table address sources
  typedef enum logic [2:0] {
    A_ZERO,
    A_IDX,
    A_IDX_INC,
    A_IDX_DEC,
    A_PTR,
    A_PTR_INC
  } addr_sel_t;

  // table write data sources
  typedef enum logic [2:0] {
    W_INIT,
    W_COPY,
    W_SPLIT,
    W_TAKE,
    W_REL,
    W_PMERGE
  } wdata_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_IDX,
    PTR_IDX_INC,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_LOAD,
    CUR_ADD,
    CUR_TRIM
  } cur_op_t;

  typedef struct packed {
    logic       load_req;
    idx_op_t    idx_op;
    ptr_op_t    ptr_op;
    cnt_op_t    cnt_op;
    cur_op_t    cur_op;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wr_data;
    logic       res_load;
    status_t    res_code;
    logic       out_push;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_zero;
    logic fit;
    logic owned;
    logic rd_free;
    logic split_ok;
    logic scan_last;
    logic has_next;
    logic has_prev;
    logic next_last;
    logic up_last;
    logic dn_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/ffa_ctrl.sv */
// Controller state machine: sequences scan, shift, split and merge steps.
`timescale 1ns / 1ps
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   pred_phase, pred_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pred_phase <= 1'b0;
    end else begin
      state      <= state_next;
      pred_phase <= pred_phase_next;
    end
  end

  always_comb begin
    state_next      = state;
    pred_phase_next = pred_phase;
    in_ready        = 1'b0;
    cmd.load_req    = 1'b0;
    cmd.idx_op      = IDX_HOLD;
    cmd.ptr_op      = PTR_HOLD;
    cmd.cnt_op      = CNT_HOLD;
    cmd.cur_op      = CUR_HOLD;
    cmd.rd_en       = 1'b0;
    cmd.rd_sel      = A_IDX;
    cmd.wr_en       = 1'b0;
    cmd.wr_sel      = A_IDX;
    cmd.wr_data     = W_COPY;
    cmd.res_load    = 1'b0;
    cmd.res_code    = ST_NO_SPACE;
    cmd.out_push    = 1'b0;

    unique case (state)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = A_ZERO;
        cmd.wr_data = W_INIT;
        state_next  = S_IDLE;
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req    = 1'b1;
          cmd.idx_op      = IDX_CLR;
          pred_phase_next = 1'b0;
          state_next      = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        if (!stat.req_free && stat.req_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = A_IDX;
          state_next = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (!stat.req_free && stat.fit) begin
          cmd.cur_op = CUR_LOAD;
          cmd.ptr_op = PTR_TOP;
          if (stat.split_ok) begin
            state_next = stat.has_next ? S_UP_RD : S_SPLIT_WR;
          end else begin
            state_next = S_TAKE_WR;
          end
        end else if (stat.req_free && stat.owned) begin
          cmd.cur_op = CUR_LOAD;
          if (stat.has_next) begin
            state_next = S_NEXT_RD;
          end else if (stat.has_prev) begin
            state_next = S_PREV_RD;
          end else begin
            state_next = S_REL_WR;
          end
        end else if (stat.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = stat.req_free ? ST_NOT_FOUND : ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SCAN_RD;
        end
      end

      // open a slot after the chosen block, top entry first
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_PTR;
        state_next = S_UP_WR;
      end

      S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = A_PTR_INC;
        cmd.wr_data = W_COPY;
        if (stat.up_last) begin
          state_next = S_SPLIT_WR;
        end else begin
          cmd.ptr_op = PTR_DEC;
          state_next = S_UP_RD;
        end
      end

      S_SPLIT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = A_IDX_INC;
        cmd.wr_data = W_SPLIT;
        cmd.cnt_op  = CNT_INC;
        cmd.cur_op  = CUR_TRIM;
        state_next  = S_TAKE_WR;
      end

      S_TAKE_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = A_IDX;
        cmd.wr_data  = W_TAKE;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_ALLOCATED;
        state_next   = S_DONE;
      end

      S_NEXT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_IDX_INC;
        state_next = S_NEXT_CHK;
      end

      S_NEXT_CHK: begin
        if (stat.rd_free) begin
          cmd.cur_op = CUR_ADD;
          cmd.ptr_op = PTR_IDX_INC;
          if (stat.next_last) begin
            cmd.cnt_op = CNT_DEC;
            state_next = stat.has_prev ? S_PREV_RD : S_REL_WR;
          end else begin
            state_next = S_DN_RD;
          end
        end else begin
          state_next = stat.has_prev ? S_PREV_RD : S_REL_WR;
        end
      end

      // close the gap left by a removed entry
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_PTR_INC;
        state_next = S_DN_WR;
      end

      S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = A_PTR;
        cmd.wr_data = W_COPY;
        if (stat.dn_last) begin
          cmd.cnt_op = CNT_DEC;
          if (pred_phase) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_FREED;
            state_next   = S_DONE;
          end else begin
            state_next = stat.has_prev ? S_PREV_RD : S_REL_WR;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_DN_RD;
        end
      end

      S_PREV_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_IDX_DEC;
        state_next = S_PREV_CHK;
      end

      S_PREV_CHK: begin
        state_next = stat.rd_free ? S_PMERGE_WR : S_REL_WR;
      end

      S_PMERGE_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = A_IDX_DEC;
        cmd.wr_data     = W_PMERGE;
        cmd.ptr_op      = PTR_IDX;
        pred_phase_next = 1'b1;
        if (stat.scan_last) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FREED;
          state_next   = S_DONE;
        end else begin
          state_next = S_DN_RD;
        end
      end

      S_REL_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = A_IDX;
        cmd.wr_data  = W_REL;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_FREED;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_push = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

/* rtl/ffa_dp.sv */
// Datapath: block table memory, scan and shift pointers, result registers.
`timescale 1ns / 1ps
module ffa_dp
  import ffa_pkg::*;
#(
  parameter int TOTAL_UNITS = FFA_TOTAL_UNITS,
  parameter int TABLE_SLOTS = FFA_TABLE_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                in_command,
  input  logic [OWNER_W-1:0]  in_owner_id,
  input  logic [REQ_W-1:0]    in_request_size,
  output logic                out_valid,
  input  logic                out_ready,
  output status_t             out_status,
  output logic [OFFSET_W-1:0] out_offset
);

  localparam int AW   = $clog2(TOTAL_UNITS);
  localparam int SW   = $clog2(TOTAL_UNITS + 1);
  localparam int IW   = $clog2(TABLE_SLOTS);
  localparam int CW   = $clog2(TABLE_SLOTS + 1);
  localparam int CMPW = (SW > REQ_W) ? SW : REQ_W;
  localparam int OFW  = AW + OFFSET_W;

  // table storage, one row per block
  logic [AW-1:0]      mem_start [TABLE_SLOTS];
  logic [SW-1:0]      mem_size  [TABLE_SLOTS];
  logic [OWNER_W-1:0] mem_owner [TABLE_SLOTS];
  logic               mem_free  [TABLE_SLOTS];

  logic [AW-1:0]      rd_start;
  logic [SW-1:0]      rd_size;
  logic [OWNER_W-1:0] rd_owner;
  logic               rd_free;

  cmd_code_t          req_cmd;
  logic [OWNER_W-1:0] req_owner;
  logic [REQ_W-1:0]   req_size;

  logic [IW-1:0]      idx;
  logic [IW-1:0]      ptr;
  logic [CW-1:0]      count;
  logic [AW-1:0]      cur_start;
  logic [SW-1:0]      cur_size;

  status_t            res_status;
  logic [OFFSET_W-1:0] res_offset;

  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [AW-1:0]      wr_start;
  logic [SW-1:0]      wr_size;
  logic [OWNER_W-1:0] wr_owner;
  logic               wr_free;

  logic [CMPW-1:0]    req_ext;
  logic [CMPW-1:0]    rd_size_ext;
  logic [CMPW-1:0]    cur_size_ext;
  logic [CMPW:0]      split_start;
  logic [CMPW-1:0]    split_size;
  logic [CW:0]        idx_c;
  logic [CW:0]        ptr_c;
  logic [CW:0]        count_c;
  logic [OFW-1:0]     off_wide;

  function automatic logic [IW-1:0] pick_addr(addr_sel_t s, logic [IW-1:0] i,
                                               logic [IW-1:0] p);
    logic [IW-1:0] a;
    a = '0;
    unique case (s)
      A_ZERO:    a = '0;
      A_IDX:     a = i;
      A_IDX_INC: a = i + IW'(1);
      A_IDX_DEC: a = i - IW'(1);
      A_PTR:     a = p;
      A_PTR_INC: a = p + IW'(1);
      default:   a = '0;
    endcase
    return a;
  endfunction

  assign rd_addr = pick_addr(cmd.rd_sel, idx, ptr);
  assign wr_addr = pick_addr(cmd.wr_sel, idx, ptr);

  assign req_ext      = CMPW'(req_size);
  assign rd_size_ext  = CMPW'(rd_size);
  assign cur_size_ext = CMPW'(cur_size);
  assign split_start  = (CMPW + 1)'(cur_start) + (CMPW + 1)'(req_size);
  assign split_size   = cur_size_ext - req_ext;

  always_comb begin
    wr_start = rd_start;
    wr_size  = rd_size;
    wr_owner = rd_owner;
    wr_free  = rd_free;
    unique case (cmd.wr_data)
      W_INIT: begin
        wr_start = '0;
        wr_size  = SW'(TOTAL_UNITS);
        wr_owner = '0;
        wr_free  = 1'b1;
      end
      W_COPY: begin
        wr_start = rd_start;
        wr_size  = rd_size;
        wr_owner = rd_owner;
        wr_free  = rd_free;
      end
      W_SPLIT: begin
        wr_start = split_start[AW-1:0];
        wr_size  = split_size[SW-1:0];
        wr_owner = '0;
        wr_free  = 1'b1;
      end
      W_TAKE: begin
        wr_start = cur_start;
        wr_size  = cur_size;
        wr_owner = req_owner;
        wr_free  = 1'b0;
      end
      W_REL: begin
        wr_start = cur_start;
        wr_size  = cur_size;
        wr_owner = '0;
        wr_free  = 1'b1;
      end
      W_PMERGE: begin
        wr_start = rd_start;
        wr_size  = rd_size + cur_size;
        wr_owner = '0;
        wr_free  = 1'b1;
      end
      default: begin
        wr_start = rd_start;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_size[wr_addr]  <= wr_size;
      mem_owner[wr_addr] <= wr_owner;
      mem_free[wr_addr]  <= wr_free;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_size  <= mem_size[rd_addr];
      rd_owner <= mem_owner[rd_addr];
      rd_free  <= mem_free[rd_addr];
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd   <= cmd_code_t'(in_command);
      req_owner <= in_owner_id;
      req_size  <= in_request_size;
    end

    unique case (cmd.idx_op)
      IDX_CLR:  idx <= '0;
      IDX_INC:  idx <= idx + IW'(1);
      default:  idx <= idx;
    endcase

    unique case (cmd.ptr_op)
      PTR_TOP:     ptr <= IW'(count - CW'(1));
      PTR_IDX:     ptr <= idx;
      PTR_IDX_INC: ptr <= idx + IW'(1);
      PTR_INC:     ptr <= ptr + IW'(1);
      PTR_DEC:     ptr <= ptr - IW'(1);
      default:     ptr <= ptr;
    endcase

    unique case (cmd.cur_op)
      CUR_LOAD: begin
        cur_start <= rd_start;
        cur_size  <= rd_size;
      end
      CUR_ADD:  cur_size <= cur_size + rd_size;
      CUR_TRIM: cur_size <= req_ext[SW-1:0];
      default:  cur_size <= cur_size;
    endcase

    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      if (cmd.res_code == ST_ALLOCATED || cmd.res_code == ST_FREED) begin
        res_offset <= off_wide[OFFSET_W-1:0];
      end else begin
        res_offset <= '0;
      end
    end

    if (cmd.out_push) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  assign off_wide = OFW'(cur_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
      if (cmd.out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign idx_c   = (CW + 1)'(idx);
  assign ptr_c   = (CW + 1)'(ptr);
  assign count_c = (CW + 1)'(count);

  assign stat.req_free  = (req_cmd == CMD_FREE);
  assign stat.req_zero  = (req_size == '0);
  assign stat.fit       = rd_free && (rd_size_ext >= req_ext);
  assign stat.owned     = !rd_free && (rd_owner == req_owner);
  assign stat.rd_free   = rd_free;
  assign stat.split_ok  = (rd_size_ext > req_ext) && (count < CW'(TABLE_SLOTS));
  assign stat.scan_last = (idx_c + (CW + 1)'(1)) == count_c;
  assign stat.has_next  = (idx_c + (CW + 1)'(1)) < count_c;
  assign stat.has_prev  = (idx != '0);
  assign stat.next_last = (idx_c + (CW + 1)'(2)) == count_c;
  assign stat.up_last   = (ptr == idx + IW'(1));
  assign stat.dn_last   = (ptr_c + (CW + 1)'(2)) == count_c;
  assign stat.out_busy  = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(TABLE_SLOTS)))
    else $error("block count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)))
    else $error("block count moved by more than one");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == CNT_INC) |-> (count < CW'(TABLE_SLOTS)))
    else $error("split with a full table");

  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_NO_SPACE || out_status == ST_NOT_FOUND))
      |-> (out_offset == '0))
    else $error("nonzero offset on a failed request");
`endif

endmodule

/* rtl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator with coalescing on free.
//
//   channel | dir | tdata                          | tuser
//   s_*     | in  | [7:0] owner_id, [17:8] req size | [0] command (0 alloc, 1 free)
//   m_*     | out | [8:0] block_offset             | [1:0] status
//
// An allocate checks each entry up to the first fit; on a split it moves later
// entries up a slot, writes the split-off free block, then the taken one. A free
// scans for the owner's block and merges it with a free next and previous neighbour,
// moving later entries down for each merge. An entry move is a table read, then a table
// write. After reset, the initial free block is written before s_tready rises.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module first_fit_block_allocator
  import ffa_pkg::*;
#(
  parameter int TOTAL_UNITS = FFA_TOTAL_UNITS,
  parameter int TABLE_SLOTS = FFA_TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] owner_id, [17:8] request_size, [23:18] zero
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [8:0] block_offset, [15:9] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  status_t             out_status;
  logic [OFFSET_W-1:0] out_offset;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffa_dp #(
    .TOTAL_UNITS (TOTAL_UNITS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (s_tuser[0]),
    .in_owner_id     (s_tdata[7:0]),
    .in_request_size (s_tdata[17:8]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (out_status),
    .out_offset      (out_offset)
  );

  assign m_tdata = {7'b0, out_offset};
  assign m_tuser = out_status;

endmodule
